[design/unsync_byte_stuff_codec_unit_macros.svh]
// ----------------------------------------------------------------------------
// ubsc assertion macros
// Concurrent assertion shorthands shared by the queue and back-end modules.
// ----------------------------------------------------------------------------
`ifndef UNSYNC_BYTE_STUFF_CODEC_UNIT_MACROS_SVH
`define UNSYNC_BYTE_STUFF_CODEC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every rising clock edge out of reset
`define UBSC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define UBSC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UBSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define UBSC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[design/ubsc_pkg.sv]
// ----------------------------------------------------------------------------
// ubsc_pkg
// Types, constants and helpers of the byte-stuffing codec.
// ----------------------------------------------------------------------------
package ubsc_pkg;

	localparam int COUNT_W             = 30;
	localparam int LENGTH_BITS_DEFAULT = 28;
	localparam int QUEUE_DEPTH_DEFAULT = 4;
	localparam int SLOT_N              = 4;

	// direction register codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// byte values of the stuffing scheme
	localparam logic [7:0] BYTE_ESC   = 8'hFF;
	localparam logic [7:0] STUFF_MASK = 8'hE0;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;

	// result slots of one job, in output order
	localparam int SLOT_HELD       = 0;
	localparam int SLOT_HELD_STUFF = 1;
	localparam int SLOT_DATA       = 2;
	localparam int SLOT_DATA_STUFF = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_in_buffer;
		logic       last_in_buffer;
		logic [7:0] boundary_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]         out_byte;
		logic               out_valid;
		logic               end_of_run;
		logic               end_of_buffer;
		logic [COUNT_W-1:0] produced_count;
	} out_beat_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [SLOT_N-1:0] slot_en;
		logic [7:0]        held_byte;
		logic [7:0]        data_byte;
		logic              data_keep;
		logic              first;
		logic              last;
	} job_t;

	// a stuffing zero follows 0xFF when the next byte could fake a sync
	function automatic logic needs_stuff(input logic [7:0] nxt);
		return ((nxt & STUFF_MASK) == STUFF_MASK) || (nxt == BYTE_ZERO);
	endfunction

endpackage

[design/unsync_byte_stuff_codec_unit.sv]
// ----------------------------------------------------------------------------
// unsync_byte_stuff_codec_unit
// Tag unsynchronisation codec: inserts or removes stuffing zeros after 0xFF.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one source byte per beat with its buffer
//   start/end flags and boundary byte. out_valid/out_ready/out_data carry
//   result beats; an input beat yields zero to four of them, the last one
//   flagged end_of_run, and the final one of a buffer carries produced_count.
//   cfg_wr_en/cfg_wr_data write the direction (0 encode, 1 decode) while the
//   block is idle; a write also drops any held byte and clears the count.
// Timing:
//   the first result beat of an input beat passes the job queue, the job
//   register and the output register; in encode a non-final byte is held
//   until the next byte comes. The back end emits one result beat per cycle
//   unless the output is stalled, so the block takes one input beat per cycle
//   while each gives one result; a stuffing zero takes a result beat of its
//   own. A four-entry job queue lets the front keep taking beats in a stall.
// Reset:
//   arst_n clears held state, the queue, the count and the output register.
// ----------------------------------------------------------------------------
module unsync_byte_stuff_codec_unit import ubsc_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data
);

	logic push;
	job_t push_data;
	logic q_full;
	logic q_empty;
	logic pop;
	job_t pop_data;

	// classification front
	ubsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.push_data   (push_data),
		.q_full      (q_full)
	);

	// job queue
	ubsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	// result back end
	ubsc_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (cfg_wr_en),
		.job_valid (!q_empty),
		.job_data  (pop_data),
		.job_pop   (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[design/ubsc_front.sv]
// ----------------------------------------------------------------------------
// ubsc_front
// Accepts input beats, tracks held and previous bytes, and classifies each
// beat into a job of up to four result slots.
// ----------------------------------------------------------------------------
module ubsc_front import ubsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_beat_t in_data,
	input  logic     cfg_wr_en,
	input  logic     cfg_wr_data,
	output logic     push,
	output job_t     push_data,
	input  logic     q_full
);

	logic       direction_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;
	logic [7:0] prev_byte_q;
	logic       accept;
	logic       held_live;
	logic [7:0] pred;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	// classify the beat
	always_comb begin
		push_data           = '0;
		push_data.held_byte = held_byte_q;
		push_data.data_byte = in_data.data_byte;
		push_data.first     = in_data.first_in_buffer;
		push_data.last      = in_data.last_in_buffer;
		held_live           = held_valid_q && !in_data.first_in_buffer;
		pred                = in_data.first_in_buffer ? in_data.boundary_byte : prev_byte_q;
		if (direction_q == DIR_ENCODE) begin
			push_data.data_keep                 = 1'b1;
			push_data.slot_en[SLOT_HELD]        = held_live;
			push_data.slot_en[SLOT_HELD_STUFF]  = held_live && (held_byte_q == BYTE_ESC)
				&& needs_stuff(in_data.data_byte);
			push_data.slot_en[SLOT_DATA]        = in_data.last_in_buffer;
			push_data.slot_en[SLOT_DATA_STUFF]  = in_data.last_in_buffer
				&& (in_data.data_byte == BYTE_ESC) && needs_stuff(in_data.boundary_byte);
		end else begin
			push_data.slot_en[SLOT_DATA] = 1'b1;
			push_data.data_keep          = !((pred == BYTE_ESC) && (in_data.data_byte == BYTE_ZERO));
		end
	end

	// direction, held byte and predecessor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= DIR_ENCODE;
			held_valid_q <= 1'b0;
			prev_byte_q  <= BYTE_ZERO;
		end else if (cfg_wr_en) begin
			direction_q  <= cfg_wr_data;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			prev_byte_q <= in_data.data_byte;
			if (direction_q == DIR_ENCODE) begin
				held_valid_q <= !in_data.last_in_buffer;
			end else if (in_data.first_in_buffer) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	// held byte payload
	always_ff @(posedge clk) begin
		if (accept && (direction_q == DIR_ENCODE) && !in_data.last_in_buffer) begin
			held_byte_q <= in_data.data_byte;
		end
	end

endmodule

[design/ubsc_queue.sv]
// ----------------------------------------------------------------------------
// ubsc_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
`include "unsync_byte_stuff_codec_unit_macros.svh"

module ubsc_queue import ubsc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`UBSC_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full, "job queue overflow")
	`UBSC_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty, "job queue underflow")

endmodule

[design/ubsc_back.sv]
// ----------------------------------------------------------------------------
// ubsc_back
// Walks the slots of each job, one result beat per cycle while the output
// is not stalled, keeps the buffer byte count and drives the output register.
// ----------------------------------------------------------------------------
`include "unsync_byte_stuff_codec_unit_macros.svh"

module ubsc_back import ubsc_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      clr,
	input  logic      job_valid,
	input  job_t      job_data,
	output logic      job_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	localparam logic [COUNT_W-1:0] COUNT_CAP = (LENGTH_BITS + 1 >= COUNT_W) ?
		{COUNT_W{1'b1}} : COUNT_W'(64'd1 << (LENGTH_BITS + 1));

	logic [SLOT_N-1:0]  cur_mask_q;
	job_t               cur_job_q;
	logic [COUNT_W-1:0] count_q;
	logic               obuf_valid_q;
	out_beat_t          obuf_q;

	logic [SLOT_N-1:0]  sel;
	logic [SLOT_N-1:0]  rem;
	logic               fire;
	logic               run_end;
	logic               buf_end;
	logic               emit_valid;
	logic [7:0]         emit_byte;
	logic [COUNT_W-1:0] count_inc;

	// pick the lowest pending slot
	always_comb begin
		sel        = cur_mask_q & (~cur_mask_q + 1'b1);
		rem        = cur_mask_q & ~sel;
		fire       = (cur_mask_q != '0) && (!obuf_valid_q || out_ready);
		run_end    = (rem == '0);
		buf_end    = run_end && cur_job_q.last;
		emit_valid = !(sel[SLOT_DATA] && !cur_job_q.data_keep);
		if (sel[SLOT_HELD]) begin
			emit_byte = cur_job_q.held_byte;
		end else if (sel[SLOT_DATA] && cur_job_q.data_keep) begin
			emit_byte = cur_job_q.data_byte;
		end else begin
			emit_byte = BYTE_ZERO;
		end
		count_inc = (emit_valid && (count_q < COUNT_CAP)) ? count_q + 1'b1 : count_q;
		job_pop   = job_valid && ((cur_mask_q == '0) || (fire && run_end));
	end

	// slot walk, byte count and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q   <= '0;
			count_q      <= '0;
			obuf_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				cur_mask_q <= job_data.slot_en;
			end else if (fire) begin
				cur_mask_q <= rem;
			end
			if (clr || (job_pop && job_data.first)) begin
				count_q <= '0;
			end else if (fire) begin
				count_q <= buf_end ? '0 : count_inc;
			end
			if (fire) begin
				obuf_valid_q <= 1'b1;
			end else if (out_ready) begin
				obuf_valid_q <= 1'b0;
			end
		end
	end

	// job and result payloads
	always_ff @(posedge clk) begin
		if (job_pop) begin
			cur_job_q <= job_data;
		end
		if (fire) begin
			obuf_q.out_byte       <= emit_byte;
			obuf_q.out_valid      <= emit_valid;
			obuf_q.end_of_run     <= run_end;
			obuf_q.end_of_buffer  <= buf_end;
			obuf_q.produced_count <= buf_end ? count_inc : '0;
		end
	end

	assign out_valid = obuf_valid_q;
	assign out_data  = obuf_q;

	`UBSC_ASSERT(a_count_cap, clk, arst_n, count_q <= COUNT_CAP, "byte count above cap")
	`UBSC_ASSERT(a_cnt_eob, clk, arst_n, fire && !buf_end |=> obuf_q.produced_count == '0, "stray count")

endmodule
